// File: hw/rtl/pstl_pkg.sv
// Shared types and constants of the sorted priority task list.
`default_nettype none
package pstl_pkg;

   localparam int REQ_W    = 2;
   localparam int ID_W     = 8;
   localparam int PRIO_W   = 8;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int CNT_W    = 5;

   typedef enum logic [REQ_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_SEARCH = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   // Command broadcast to every cell of the row.
   typedef struct packed {
      logic ins_mode;  // request is an insert
      logic ins_en;    // insert that really shifts (list not full)
      logic rem_en;    // remove: cells behind the first hit pull forward
   } cmd_type;

   // Control handed from a cell to its right-hand neighbour.
   typedef struct packed {
      logic gt;    // this entry outranks the new priority
      logic seen;  // a matching id sits at or left of this cell
   } link_type;

endpackage
`default_nettype wire

// File: hw/rtl/pstl_req_if.sv
// Request channel: valid/ready handshake with the request payload.
`default_nettype none
interface pstl_req_if;
   import pstl_pkg::*;

   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [ID_W-1:0]   task_id;
   logic [PRIO_W-1:0] priority_req;

   modport source (output valid, output req_type, output task_id, output priority_req,
                   input ready);
   modport sink   (input valid, input req_type, input task_id, input priority_req,
                   output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pstl_rsp_if.sv
// Response channel: valid/ready handshake with the result payload.
`default_nettype none
interface pstl_rsp_if;
   import pstl_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [POS_W-1:0]    position;
   logic                head_valid;
   logic [ID_W-1:0]     head_task;
   logic [PRIO_W-1:0]   head_prio;
   logic [CNT_W-1:0]    entry_count;

   modport source (output valid, output status, output position, output head_valid,
                   output head_task, output head_prio, output entry_count,
                   input ready);
   modport sink   (input valid, input status, input position, input head_valid,
                   input head_task, input head_prio, input entry_count,
                   output ready);
endinterface
`default_nettype wire

// File: hw/rtl/priority_sorted_task_list.sv
// Top level of the sorted priority task list: row of cells, fill count and response register.
`default_nettype none
// Keeps up to MAX_TASKS (task id, priority) entries sorted by descending priority in a row
// of cells; a new entry goes before older ones of equal priority. Every request (insert,
// remove, search) is handled in a single pass: all cells compare against the request in
// parallel and shift by at most one place, and the result appears in the response register
// on the next cycle. A new request beat is taken each cycle while the response register is
// empty or being drained, so throughput is one request per cycle.
// Only the low TASK_ID_BITS bits of task_id (at most 8) are stored and compared. There is
// no clearing pass after reset; slots beyond the fill count are never read.
module priority_sorted_task_list_core #(
   parameter int MAX_TASKS    = 16,
   parameter int TASK_ID_BITS = 8
) (
   input  logic            clock,
   input  logic            reset,
   pstl_req_if.sink        req_ch,
   pstl_rsp_if.source      rsp_ch
);
   import pstl_pkg::*;

   localparam int KeepW = (TASK_ID_BITS < ID_W) ? TASK_ID_BITS : ID_W;
   localparam int CntW  = $clog2(MAX_TASKS + 1);
   localparam int IdxW  = $clog2(MAX_TASKS);

   logic [CntW-1:0]   count_ff, count_in;
   logic              accept;
   logic              full;
   logic              is_insert, is_remove, is_search;
   cmd_type           cmd;
   logic [KeepW-1:0]  new_tid;

   link_type          link [MAX_TASKS+1];
   logic [KeepW-1:0]  tid_q   [MAX_TASKS+2];
   logic [PRIO_W-1:0] prio_q  [MAX_TASKS+2];
   logic [KeepW-1:0]  tid_nx  [MAX_TASKS];
   logic [PRIO_W-1:0] prio_nx [MAX_TASKS];
   logic [MAX_TASKS-1:0] mark;

   logic [IdxW-1:0]   hit_idx;
   logic              found;
   status_type        status;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [POS_W-1:0]    position_ff;
   logic                head_valid_ff;
   logic [ID_W-1:0]     head_task_ff;
   logic [PRIO_W-1:0]   head_prio_ff;
   logic [CNT_W-1:0]    entry_count_ff;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign full         = (count_ff == CntW'(MAX_TASKS));
   assign new_tid      = req_ch.task_id[KeepW-1:0];

   always_comb begin
      is_insert = 1'b0;
      is_remove = 1'b0;
      is_search = 1'b0;
      case (req_ch.req_type)
         OP_INSERT: is_insert = 1'b1;
         OP_REMOVE: is_remove = 1'b1;
         OP_SEARCH: is_search = 1'b1;
         default:   ;
      endcase
   end

   assign cmd.ins_mode = is_insert;
   assign cmd.ins_en   = accept && is_insert && !full;
   assign cmd.rem_en   = accept && is_remove;

   // Ends of the row: cell 0 always sees an outranking left side, the last cell pulls zeros.
   assign link[0].gt         = 1'b1;
   assign link[0].seen       = 1'b0;
   assign tid_q[0]           = '0;
   assign prio_q[0]          = '0;
   assign tid_q[MAX_TASKS+1] = '0;
   assign prio_q[MAX_TASKS+1] = '0;

   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      pstl_cell #(.IdW(KeepW)) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .slot_valid (CntW'(i) < count_ff),
         .new_tid    (new_tid),
         .new_prio   (req_ch.priority_req),
         .link_in    (link[i]),
         .left_tid   (tid_q[i]),
         .left_prio  (prio_q[i]),
         .right_tid  (tid_q[i+2]),
         .right_prio (prio_q[i+2]),
         .link_out   (link[i+1]),
         .tid_q      (tid_q[i+1]),
         .prio_q     (prio_q[i+1]),
         .tid_nx     (tid_nx[i]),
         .prio_nx    (prio_nx[i]),
         .mark       (mark[i])
      );
   end

   // At most one cell is marked, so the index is an OR of the marked positions.
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         if (mark[i]) begin
            hit_idx = hit_idx | IdxW'(i);
         end
      end
   end

   assign found = |mark;

   always_comb begin
      status   = ST_NOT_FOUND;
      count_in = count_ff;
      if (is_insert) begin
         if (full) begin
            status = ST_FULL;
         end else begin
            status   = ST_OK;
            count_in = count_ff + CntW'(1);
         end
      end else if (is_remove) begin
         if (found) begin
            status   = ST_OK;
            count_in = count_ff - CntW'(1);
         end
      end else if (is_search) begin
         if (found) begin
            status = ST_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff      <= status;
         position_ff    <= (status == ST_OK) ? POS_W'(hit_idx) : '0;
         head_valid_ff  <= (count_in != '0);
         head_task_ff   <= (count_in != '0) ? ID_W'(tid_nx[0]) : '0;
         head_prio_ff   <= (count_in != '0) ? prio_nx[0] : '0;
         entry_count_ff <= CNT_W'(count_in);
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.position    = position_ff;
   assign rsp_ch.head_valid  = head_valid_ff;
   assign rsp_ch.head_task   = head_task_ff;
   assign rsp_ch.head_prio   = head_prio_ff;
   assign rsp_ch.entry_count = entry_count_ff;

endmodule
`default_nettype wire

// File: hw/rtl/pstl_cell.sv
// One slot of the sorted list: holds an entry, compares it and shifts with its neighbours.
`default_nettype none
module pstl_cell #(
   parameter int IdW = 8
) (
   input  logic                        clock,
   input  pstl_pkg::cmd_type           cmd,
   input  logic                        slot_valid,
   input  logic [IdW-1:0]              new_tid,
   input  logic [pstl_pkg::PRIO_W-1:0] new_prio,
   input  pstl_pkg::link_type          link_in,
   input  logic [IdW-1:0]              left_tid,
   input  logic [pstl_pkg::PRIO_W-1:0] left_prio,
   input  logic [IdW-1:0]              right_tid,
   input  logic [pstl_pkg::PRIO_W-1:0] right_prio,
   output pstl_pkg::link_type          link_out,
   output logic [IdW-1:0]              tid_q,
   output logic [pstl_pkg::PRIO_W-1:0] prio_q,
   output logic [IdW-1:0]              tid_nx,
   output logic [pstl_pkg::PRIO_W-1:0] prio_nx,
   output logic                        mark
);
   import pstl_pkg::*;

   logic [IdW-1:0]    tid_ff, tid_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic              gt;
   logic              hit;

   assign gt  = slot_valid && (prio_ff > new_prio);
   assign hit = slot_valid && (tid_ff == new_tid);

   assign link_out.gt   = gt;
   assign link_out.seen = link_in.seen | hit;

   // Insert: the first cell not outranking the new entry takes it, those behind shift right.
   // Remove: the first hit and every cell behind it pull from the right-hand neighbour.
   always_comb begin
      tid_in  = tid_ff;
      prio_in = prio_ff;
      if (cmd.ins_en && !gt) begin
         if (link_in.gt) begin
            tid_in  = new_tid;
            prio_in = new_prio;
         end else begin
            tid_in  = left_tid;
            prio_in = left_prio;
         end
      end else if (cmd.rem_en && (link_in.seen || hit)) begin
         tid_in  = right_tid;
         prio_in = right_prio;
      end
   end

   assign mark = cmd.ins_mode ? (!gt && link_in.gt) : (hit && !link_in.seen);

   always_ff @(posedge clock) begin
      tid_ff  <= tid_in;
      prio_ff <= prio_in;
   end

   assign tid_q   = tid_ff;
   assign prio_q  = prio_ff;
   assign tid_nx  = tid_in;
   assign prio_nx = prio_in;

endmodule
`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the sorted priority task list core.
`timescale 1ns / 1ps

module tb_top;
   import pstl_pkg::*;

   localparam int LIST_DEPTH  = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SHOW_LIMIT  = 10;
   localparam logic [REQ_W-1:0] OP_RESERVED = 2'd3;

   typedef struct packed {
      status_type        status;
      logic [POS_W-1:0]  position;
      logic              head_valid;
      logic [ID_W-1:0]   head_task;
      logic [PRIO_W-1:0] head_prio;
      logic [CNT_W-1:0]  entry_count;
   } list_rsp_type;

   logic clock;
   logic reset;

   pstl_req_if req_if ();
   pstl_rsp_if rsp_if ();

   priority_sorted_task_list_core #(
      .MAX_TASKS    (LIST_DEPTH),
      .TASK_ID_BITS (ID_W)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // Shadow copy of the list, kept in step with accepted requests
   logic [ID_W-1:0]   shadow_id   [LIST_DEPTH];
   logic [PRIO_W-1:0] shadow_prio [LIST_DEPTH];
   int                shadow_len;

   list_rsp_type pending_rsp[$];
   int        mismatches;
   int        cycle_count;
   bit        req_gaps_on;
   bit        rsp_stalls_on;
   int        rsp_hold_req;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int find_task(logic [ID_W-1:0] id);
      for (int i = 0; i < shadow_len; i++)
         if (shadow_id[i] == id) return i;
      return -1;
   endfunction

   // Applies one request to the shadow list and returns the response it should give
   function automatic list_rsp_type apply_to_list(logic [REQ_W-1:0] op, logic [ID_W-1:0] id,
                                                  logic [PRIO_W-1:0] prio);
      list_rsp_type r;
      int        at;
      r.status   = ST_NOT_FOUND;
      r.position = '0;
      case (op)
         OP_INSERT: begin
            if (shadow_len >= LIST_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               at = 0;
               while (at < shadow_len && shadow_prio[at] > prio) at++;
               for (int i = shadow_len; i > at; i--) begin
                  shadow_id[i]   = shadow_id[i-1];
                  shadow_prio[i] = shadow_prio[i-1];
               end
               shadow_id[at]   = id;
               shadow_prio[at] = prio;
               shadow_len++;
               r.status   = ST_OK;
               r.position = at[POS_W-1:0];
            end
         end
         OP_REMOVE: begin
            at = find_task(id);
            if (at >= 0) begin
               for (int i = at; i + 1 < shadow_len; i++) begin
                  shadow_id[i]   = shadow_id[i+1];
                  shadow_prio[i] = shadow_prio[i+1];
               end
               shadow_len--;
               r.status   = ST_OK;
               r.position = at[POS_W-1:0];
            end
         end
         OP_SEARCH: begin
            at = find_task(id);
            if (at >= 0) begin
               r.status   = ST_OK;
               r.position = at[POS_W-1:0];
            end
         end
         default: ;
      endcase
      r.head_valid  = (shadow_len > 0);
      r.head_task   = (shadow_len > 0) ? shadow_id[0] : '0;
      r.head_prio   = (shadow_len > 0) ? shadow_prio[0] : '0;
      r.entry_count = shadow_len[CNT_W-1:0];
      return r;
   endfunction

   // Offers one request beat, holds it until taken, then records the expected response
   task automatic send_req(logic [REQ_W-1:0] op, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.req_type     <= op;
      req_if.task_id      <= id;
      req_if.priority_req <= prio;
      do @(posedge clock); while (!req_if.ready);
      pending_rsp.push_back(apply_to_list(op, id, prio));
   endtask

   // Random request, biased so that removes and searches mostly hit a stored id
   task automatic send_random(int insert_weight);
      int                r;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
      r = $urandom_range(0, 99);
      if (shadow_len > 0 && $urandom_range(0, 3) != 0)
         id = shadow_id[$urandom_range(0, shadow_len - 1)];
      else if ($urandom_range(0, 1))
         id = ID_W'($urandom_range(0, 7));
      else
         id = ID_W'($urandom_range(0, 255));
      // plenty of ties so the equal-priority ordering gets exercised
      case ($urandom_range(0, 3))
         0:       prio = $urandom_range(0, 1) ? 8'hff : 8'h00;
         1:       prio = PRIO_W'(8'h40 + $urandom_range(0, 3));
         default: prio = PRIO_W'($urandom_range(0, 255));
      endcase
      if (r < 3)
         send_req(OP_RESERVED, id, prio);
      else if (r < insert_weight)
         send_req(OP_INSERT, id, prio);
      else if ($urandom_range(0, 9) < 6)
         send_req(OP_REMOVE, id, prio);
      else
         send_req(OP_SEARCH, id, prio);
   endtask

   task automatic test_directed();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      send_req(OP_SEARCH, 8'h12, 8'h00);   // empty list
      send_req(OP_REMOVE, 8'h12, 8'h00);
      send_req(OP_RESERVED, 8'hff, 8'hff);
      send_req(OP_INSERT, 8'hff, 8'hff);
      send_req(OP_INSERT, 8'h00, 8'h00);
      send_req(OP_INSERT, 8'h55, 8'hff);   // tie: goes before the older 0xff entry
      send_req(OP_INSERT, 8'haa, 8'h80);
      send_req(OP_INSERT, 8'haa, 8'h80);   // duplicate id
      send_req(OP_SEARCH, 8'haa, 8'h00);
      send_req(OP_REMOVE, 8'haa, 8'h00);
      send_req(OP_RESERVED, 8'h55, 8'h00);
      send_req(OP_SEARCH, 8'h77, 8'h00);
      send_req(OP_REMOVE, 8'h77, 8'h00);
      for (int i = 0; i < 12; i++)
         send_req(OP_INSERT, 8'(8'h30 + i), 8'(i * 21));
      send_req(OP_INSERT, 8'h99, 8'h7f);   // list full
   endtask

   task automatic test_back_to_back();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      for (int i = 0; i < 150; i++)
         send_random((i < 75) ? 30 : 70);
   endtask

   task automatic test_backpressure();
      req_gaps_on   = 1'b0;
      rsp_stalls_on = 1'b0;
      rsp_hold_req  = 120;
      for (int i = 0; i < 40; i++)
         send_random(60);
   endtask

   task automatic test_random(int n_items);
      int phase;
      phase = 0;
      for (int i = 0; i < n_items; i++) begin
         if (i % 100 == 0) begin
            phase++;
            // every fourth phase runs flat out on both sides
            req_gaps_on   = (phase % 4 != 0);
            rsp_stalls_on = (phase % 4 != 0);
         end
         send_random((phase % 2) ? 75 : 30);
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Response side: random stalls, plus a long hold when one is requested
   initial begin
      int hold_left;
      hold_left    = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req > 0) begin
            hold_left    = rsp_hold_req;
            rsp_hold_req = 0;
         end else if (hold_left == 0 && rsp_stalls_on && $urandom_range(0, 99) < 20) begin
            hold_left = pick_gap();
         end
         rsp_if.ready <= (hold_left == 0);
         if (hold_left > 0) hold_left--;
      end
   end

   always @(posedge clock) begin
      list_rsp_type got;
      list_rsp_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.status      = status_type'(rsp_if.status);
         got.position    = rsp_if.position;
         got.head_valid  = rsp_if.head_valid;
         got.head_task   = rsp_if.head_task;
         got.head_prio   = rsp_if.head_prio;
         got.entry_count = rsp_if.entry_count;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
               $display("unexpected response beat: %p", got);
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= SHOW_LIMIT)
                  $display({"mismatch: exp st=%0d pos=%0d hv=%0d id=%h pr=%h cnt=%0d",
                            " | act st=%0d pos=%0d hv=%0d id=%h pr=%h cnt=%0d"},
                     want.status, want.position, want.head_valid, want.head_task,
                     want.head_prio, want.entry_count, got.status, got.position,
                     got.head_valid, got.head_task, got.head_prio, got.entry_count);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[priority_sorted_task_list_core] ERROR");
         $finish;
      end
   end

   initial begin
      mismatches          = 0;
      cycle_count         = 0;
      shadow_len          = 0;
      rsp_hold_req        = 0;
      req_gaps_on         = 1'b0;
      rsp_stalls_on       = 1'b0;
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.req_type     <= OP_INSERT;
      req_if.task_id      <= '0;
      req_if.priority_req <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_back_to_back();
      test_backpressure();
      test_random(1550);
      drain();

      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("[priority_sorted_task_list_core] OK");
      else
         $display("[priority_sorted_task_list_core] ERROR");
      $finish;
   end

endmodule
